### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the token bucket table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define MTB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Expression that must never hold at a clock edge.
`define MTB_NEVER(label, clk, rst_n, expr) \
    `MTB_ASSERT(label, clk, rst_n, !(expr))

`endif

### rtl/mtb_pkg.sv
// Shared constants, types and helper functions for the token bucket table.
// No dependencies.
package mtb_pkg;

    localparam int unsigned BUCKETS  = 1024;
    localparam int unsigned TOKEN_W  = 16;

    // Fixed widths of the word fields
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned ID_IN_W  = 10;
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned GRANT_W  = 16;

    // Valid map geometry: rows of ROW_BITS flags, at least two rows
    localparam int unsigned COL_W     = (BUCKETS < 32) ? $clog2(BUCKETS) : 5;
    localparam int unsigned ROW_BITS  = 1 << COL_W;
    localparam int unsigned ROWS_RAW  = (BUCKETS + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned ROWS      = (ROWS_RAW < 2) ? 2 : ROWS_RAW;
    localparam int unsigned ROW_W     = $clog2(ROWS);
    localparam int unsigned ENT_W     = ROW_W + COL_W;
    localparam int unsigned REC_DEPTH = ROWS * ROW_BITS;

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE      = 3'd0,
        FN_FETCH       = 3'd1,
        FN_GIVE        = 3'd2,
        FN_DESTROY     = 3'd3,
        FN_DESTROY_ALL = 3'd4,
        FN_TICK        = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BAD_ID = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RMW,
        S_CREATE,
        S_CLEAR,
        S_TICK,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [TOKEN_W-1:0] rate;
        logic [TOKEN_W-1:0] limit;
        logic [TOKEN_W-1:0] tokens;
    } t_bucket;

    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    slot;
        logic [GRANT_W-1:0]   granted;
    } t_result;

    typedef struct packed {
        logic                rd_en;
        logic [ROW_W-1:0]    rd_row;
        logic                wr_en;
        logic [ROW_W-1:0]    wr_row;
        logic [ROW_BITS-1:0] wr_bits;
    } t_map_req;

    typedef struct packed {
        logic             rd_en;
        logic [ENT_W-1:0] rd_ent;
        logic             wr_en;
        logic [ENT_W-1:0] wr_ent;
        t_bucket          wr_data;
    } t_rec_req;

    typedef struct packed {
        logic             found;
        logic [COL_W-1:0] col;
    } t_free;

    // Lowest free column of a map row; columns past the last bucket count as taken
    function automatic t_free find_free(input logic [ROW_BITS-1:0] bits,
                                        input logic [ROW_W-1:0] row);
        t_free            f;
        logic [ENT_W-1:0] ent;
        f   = '0;
        ent = '0;
        for (int k = ROW_BITS - 1; k >= 0; k--) begin
            ent = {row, COL_W'(k)};
            if (!bits[k] && (32'(ent) < BUCKETS)) begin
                f.found = 1'b1;
                f.col   = COL_W'(k);
            end
        end
        return f;
    endfunction

    // Add and clamp at the limit
    function automatic logic [TOKEN_W-1:0] sat_add(input logic [TOKEN_W-1:0] a,
                                                   input logic [TOKEN_W-1:0] b,
                                                   input logic [TOKEN_W-1:0] lim);
        logic [TOKEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[TOKEN_W-1:0];
    endfunction

endpackage

### rtl/multi_token_bucket_table.sv
// Top level of the token bucket table: sequencer, allocation map and bucket store.
// Depends on mtb_pkg, mtb_valid_map, mtb_bucket_mem, mtb_ctrl and assert_macros.svh.
//
// A table of mtb_pkg::BUCKETS token buckets served one request word at a time.
// Fetch, give back, destroy one and unused function codes are a read-modify-write:
// the accepting cycle reads the bucket record and its allocation row, the next
// one modifies and writes back. Create walks the allocation map one row of 32
// flags per cycle until it finds a free slot, and reports full if none is free.
// Destroy all clears the map one row a cycle. Tick walks every record through
// the single read and write port of the bucket store. After reset a clearing
// pass over the map runs with o_ready low. A finished result waits in the output
// register; a new word is taken as soon as the sequencer is idle, and a second
// result held back by the consumer parks in a hold stage until the output
// register frees.
`include "assert_macros.svh"

module multi_token_bucket_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mtb_pkg::FUNC_W-1:0]      i_func,
    input  logic [mtb_pkg::ID_IN_W-1:0]     i_bucket_id,
    input  logic [mtb_pkg::FIELD_W-1:0]     i_rate,
    input  logic [mtb_pkg::FIELD_W-1:0]     i_burst_limit,
    input  logic [mtb_pkg::FIELD_W-1:0]     i_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mtb_pkg::STATUS_W-1:0]    o_status,
    output logic [mtb_pkg::SLOT_W-1:0]      o_slot,
    output logic [mtb_pkg::GRANT_W-1:0]     o_granted
);

    mtb_pkg::t_map_req             map_req;
    mtb_pkg::t_rec_req             rec_req;
    logic [mtb_pkg::ROW_BITS-1:0]  map_bits;
    mtb_pkg::t_bucket              rec_data;

    // Allocation flags, read a row at a time
    mtb_valid_map u_map (
        .i_clk     (i_clk),
        .i_req     (map_req),
        .o_rd_bits (map_bits)
    );

    // Per-bucket rate, limit and token count
    mtb_bucket_mem u_store (
        .i_clk     (i_clk),
        .i_req     (rec_req),
        .o_rd_data (rec_data)
    );

    // Sequencer: one word in flight, read-modify-write with no overlap on any entry
    mtb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_bucket_id   (i_bucket_id),
        .i_rate        (i_rate),
        .i_burst_limit (i_burst_limit),
        .i_count       (i_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_granted     (o_granted),
        .o_map_req     (map_req),
        .i_map_bits    (map_bits),
        .o_rec_req     (rec_req),
        .i_rec_data    (rec_data)
    );

    // Create must mark a flag in the same map row as the slot it initialises
    `MTB_ASSERT(a_create_same_slot, i_clk, i_rst_n, (map_req.wr_en && rec_req.wr_en) |-> (rec_req.wr_ent[mtb_pkg::ENT_W-1:mtb_pkg::COL_W] == map_req.wr_row))
    // An accepted word keeps the sequencer busy for at least the next cycle
    `MTB_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready)
    // A result only appears out of work in progress
    `MTB_ASSERT(a_result_from_work, i_clk, i_rst_n, $rose(o_valid) |-> !$past(o_ready))
    // No memory writes while idle
    `MTB_NEVER(a_no_idle_write, i_clk, i_rst_n, o_ready && (map_req.wr_en || rec_req.wr_en))

endmodule

### rtl/mtb_valid_map.sv
// Allocation map: one flag per bucket, packed into rows, one read and one write port.
// Depends on mtb_pkg.
module mtb_valid_map (
    input  logic                          i_clk,
    input  mtb_pkg::t_map_req             i_req,
    output logic [mtb_pkg::ROW_BITS-1:0]  o_rd_bits
);

    logic [mtb_pkg::ROW_BITS-1:0] r_mem [mtb_pkg::ROWS];
    logic [mtb_pkg::ROW_BITS-1:0] r_rd_bits;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_row] <= i_req.wr_bits;
        end
        if (i_req.rd_en) begin
            r_rd_bits <= r_mem[i_req.rd_row];
        end
    end

    assign o_rd_bits = r_rd_bits;

endmodule

### rtl/mtb_bucket_mem.sv
// Bucket record store: rate, limit and token count per slot, one read and one write port.
// Depends on mtb_pkg.
module mtb_bucket_mem (
    input  logic               i_clk,
    input  mtb_pkg::t_rec_req  i_req,
    output mtb_pkg::t_bucket   o_rd_data
);

    mtb_pkg::t_bucket r_mem [mtb_pkg::REC_DEPTH];
    mtb_pkg::t_bucket r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_ent] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_ent];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/mtb_ctrl.sv
// Request sequencer: read-modify-write of one bucket, table walks, output register.
// Depends on mtb_pkg; drives mtb_valid_map and mtb_bucket_mem.
module mtb_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mtb_pkg::FUNC_W-1:0]      i_func,
    input  logic [mtb_pkg::ID_IN_W-1:0]     i_bucket_id,
    input  logic [mtb_pkg::FIELD_W-1:0]     i_rate,
    input  logic [mtb_pkg::FIELD_W-1:0]     i_burst_limit,
    input  logic [mtb_pkg::FIELD_W-1:0]     i_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mtb_pkg::STATUS_W-1:0]    o_status,
    output logic [mtb_pkg::SLOT_W-1:0]      o_slot,
    output logic [mtb_pkg::GRANT_W-1:0]     o_granted,
    output mtb_pkg::t_map_req               o_map_req,
    input  logic [mtb_pkg::ROW_BITS-1:0]    i_map_bits,
    output mtb_pkg::t_rec_req               o_rec_req,
    input  mtb_pkg::t_bucket                i_rec_data
);

    localparam logic [mtb_pkg::ROW_W-1:0] LAST_ROW = mtb_pkg::ROW_W'(mtb_pkg::ROWS - 1);
    localparam logic [mtb_pkg::ENT_W-1:0] LAST_ENT = mtb_pkg::ENT_W'(mtb_pkg::REC_DEPTH - 1);

    mtb_pkg::t_state                r_state, n_state;
    logic [mtb_pkg::FUNC_W-1:0]     r_func;
    logic [mtb_pkg::ID_IN_W-1:0]    r_id;
    logic                           r_in_range;
    logic [mtb_pkg::TOKEN_W-1:0]    r_rate, r_limit, r_count;
    logic [mtb_pkg::ROW_W-1:0]      r_row, n_row;
    logic [mtb_pkg::ENT_W-1:0]      r_ent, n_ent;
    mtb_pkg::t_result               r_pend, r_out, res;
    logic                           r_o_valid;

    logic                           accept;
    logic                           fin;
    logic                           out_free;
    logic [mtb_pkg::ENT_W-1:0]      id_ent;
    mtb_pkg::t_func                 in_func;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign id_ent   = mtb_pkg::ENT_W'(i_bucket_id);
    assign in_func  = mtb_pkg::t_func'(i_func);
    assign o_ready  = (r_state == mtb_pkg::S_IDLE);

    // Datapath and memory requests
    always_comb begin
        mtb_pkg::t_free              hit;
        mtb_pkg::t_bucket            cur;
        logic                        live;
        logic [mtb_pkg::TOKEN_W-1:0] grant;
        logic [mtb_pkg::ENT_W-1:0]   ent_nxt;
        logic [mtb_pkg::COL_W-1:0]   col;

        o_map_req = '0;
        o_rec_req = '0;
        fin       = 1'b0;
        res       = '0;
        n_row     = r_row;
        n_ent     = r_ent;
        cur       = i_rec_data;
        col       = r_ent[mtb_pkg::COL_W-1:0];
        live      = r_in_range && i_map_bits[col];
        grant     = (r_count < cur.tokens) ? r_count : cur.tokens;
        hit       = mtb_pkg::find_free(i_map_bits, r_row);
        ent_nxt   = r_ent + mtb_pkg::ENT_W'(1);

        unique case (r_state)
            mtb_pkg::S_INIT: begin
                o_map_req.wr_en  = 1'b1;
                o_map_req.wr_row = r_row;
                n_row            = r_row + mtb_pkg::ROW_W'(1);
            end
            mtb_pkg::S_IDLE: begin
                if (accept) begin
                    o_map_req.rd_en = 1'b1;
                    o_rec_req.rd_en = 1'b1;
                    n_row           = '0;
                    if (in_func == mtb_pkg::FN_CREATE || in_func == mtb_pkg::FN_TICK) begin
                        o_map_req.rd_row = '0;
                    end else begin
                        o_map_req.rd_row = id_ent[mtb_pkg::ENT_W-1:mtb_pkg::COL_W];
                    end
                    if (in_func == mtb_pkg::FN_TICK) begin
                        o_rec_req.rd_ent = '0;
                        n_ent            = '0;
                    end else begin
                        o_rec_req.rd_ent = id_ent;
                        n_ent            = id_ent;
                    end
                end
            end
            mtb_pkg::S_RMW: begin
                fin          = 1'b1;
                res.slot     = r_id;
                res.status   = live ? mtb_pkg::STAT_OK : mtb_pkg::STAT_BAD_ID;
                unique case (mtb_pkg::t_func'(r_func))
                    mtb_pkg::FN_FETCH: begin
                        if (live && cur.tokens == '0) begin
                            res.status = mtb_pkg::STAT_EMPTY;
                        end else if (live) begin
                            res.granted       = mtb_pkg::GRANT_W'(grant);
                            o_rec_req.wr_en   = 1'b1;
                            o_rec_req.wr_ent  = r_ent;
                            o_rec_req.wr_data = cur;
                            o_rec_req.wr_data.tokens = cur.tokens - grant;
                        end
                    end
                    mtb_pkg::FN_GIVE: begin
                        if (live) begin
                            o_rec_req.wr_en   = 1'b1;
                            o_rec_req.wr_ent  = r_ent;
                            o_rec_req.wr_data = cur;
                            o_rec_req.wr_data.tokens =
                                mtb_pkg::sat_add(cur.tokens, r_count, cur.limit);
                        end
                    end
                    mtb_pkg::FN_DESTROY: begin
                        if (live) begin
                            o_map_req.wr_en   = 1'b1;
                            o_map_req.wr_row  = r_ent[mtb_pkg::ENT_W-1:mtb_pkg::COL_W];
                            o_map_req.wr_bits = i_map_bits
                                & ~(mtb_pkg::ROW_BITS'(1) << col);
                        end
                    end
                    default: begin
                        res.status = mtb_pkg::STAT_BAD_ID;
                    end
                endcase
            end
            mtb_pkg::S_CREATE: begin
                if (hit.found) begin
                    fin               = 1'b1;
                    res.status        = mtb_pkg::STAT_OK;
                    res.slot          = mtb_pkg::SLOT_W'({r_row, hit.col});
                    o_map_req.wr_en   = 1'b1;
                    o_map_req.wr_row  = r_row;
                    o_map_req.wr_bits = i_map_bits | (mtb_pkg::ROW_BITS'(1) << hit.col);
                    o_rec_req.wr_en   = 1'b1;
                    o_rec_req.wr_ent  = {r_row, hit.col};
                    o_rec_req.wr_data = '{rate: r_rate, limit: r_limit, tokens: '0};
                end else if (r_row == LAST_ROW) begin
                    fin        = 1'b1;
                    res.status = mtb_pkg::STAT_FULL;
                end else begin
                    n_row            = r_row + mtb_pkg::ROW_W'(1);
                    o_map_req.rd_en  = 1'b1;
                    o_map_req.rd_row = n_row;
                end
            end
            mtb_pkg::S_CLEAR: begin
                o_map_req.wr_en  = 1'b1;
                o_map_req.wr_row = r_row;
                n_row            = r_row + mtb_pkg::ROW_W'(1);
                if (r_row == LAST_ROW) begin
                    fin        = 1'b1;
                    res.status = mtb_pkg::STAT_OK;
                    res.slot   = r_id;
                end
            end
            mtb_pkg::S_TICK: begin
                if (i_map_bits[col]) begin
                    o_rec_req.wr_en   = 1'b1;
                    o_rec_req.wr_ent  = r_ent;
                    o_rec_req.wr_data = cur;
                    o_rec_req.wr_data.tokens =
                        mtb_pkg::sat_add(cur.tokens, cur.rate, cur.limit);
                end
                if (r_ent == LAST_ENT) begin
                    fin        = 1'b1;
                    res.status = mtb_pkg::STAT_OK;
                    res.slot   = r_id;
                end else begin
                    n_ent            = ent_nxt;
                    o_map_req.rd_en  = 1'b1;
                    o_map_req.rd_row = ent_nxt[mtb_pkg::ENT_W-1:mtb_pkg::COL_W];
                    o_rec_req.rd_en  = 1'b1;
                    o_rec_req.rd_ent = ent_nxt;
                end
            end
            mtb_pkg::S_HOLD: begin
                fin = 1'b1;
                res = r_pend;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtb_pkg::S_INIT: begin
                if (r_row == LAST_ROW) begin
                    n_state = mtb_pkg::S_IDLE;
                end
            end
            mtb_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (in_func)
                        mtb_pkg::FN_CREATE:      n_state = mtb_pkg::S_CREATE;
                        mtb_pkg::FN_DESTROY_ALL: n_state = mtb_pkg::S_CLEAR;
                        mtb_pkg::FN_TICK:        n_state = mtb_pkg::S_TICK;
                        default:                 n_state = mtb_pkg::S_RMW;
                    endcase
                end
            end
            default: begin
                if (fin) begin
                    n_state = out_free ? mtb_pkg::S_IDLE : mtb_pkg::S_HOLD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mtb_pkg::S_INIT;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            if (fin && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (accept) begin
            r_func     <= i_func;
            r_id       <= i_bucket_id;
            r_in_range <= (32'(i_bucket_id) < mtb_pkg::BUCKETS);
            r_rate     <= mtb_pkg::TOKEN_W'(i_rate);
            r_limit    <= mtb_pkg::TOKEN_W'(i_burst_limit);
            r_count    <= mtb_pkg::TOKEN_W'(i_count);
        end
        if (fin && !out_free) begin
            r_pend <= res;
        end
        if (fin && out_free) begin
            r_out <= res;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_status  = r_out.status;
    assign o_slot    = r_out.slot;
    assign o_granted = r_out.granted;

endmodule
